// ===== rtl/c2d_pkg.sv =====
// ----------------------------------------------------------------------------
// c2d_pkg
// Shared types, widths, register indexes and reset values of the 3x3
// zero-padded convolution block.
// ----------------------------------------------------------------------------
package c2d_pkg;

   localparam int PIXEL_BITS         = 8;
   localparam int COEF_BITS          = 8;
   localparam int KERNEL_SIZE        = 3;
   localparam int RESULT_BITS        = 20;
   localparam int PRODUCT_BITS       = PIXEL_BITS + COEF_BITS + 1;
   localparam int DIM_BITS           = 11;
   localparam int KERNEL_ROW_BITS    = KERNEL_SIZE * COEF_BITS;
   localparam int CSR_INDEX_BITS     = 3;
   localparam int CSR_DATA_BITS      = KERNEL_ROW_BITS;
   localparam int DEFAULT_MAX_WIDTH  = 1024;
   localparam int DEFAULT_MAX_HEIGHT = 1024;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_KERNEL_ROW0  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_KERNEL_ROW1  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_KERNEL_ROW2  = 3'd4;

   localparam logic [DIM_BITS-1:0]        RESET_IMAGE_WIDTH  = 11'd5;
   localparam logic [DIM_BITS-1:0]        RESET_IMAGE_HEIGHT = 11'd5;
   localparam logic [KERNEL_ROW_BITS-1:0] RESET_KERNEL_ROW0  = 24'd66305;
   localparam logic [KERNEL_ROW_BITS-1:0] RESET_KERNEL_ROW1  = 24'd1280;
   localparam logic [KERNEL_ROW_BITS-1:0] RESET_KERNEL_ROW2  = 24'd131330;

   typedef logic [PIXEL_BITS-1:0] pixel_type;

   typedef struct packed {
      logic      kind;
      pixel_type pixel;
   } req_type;

   typedef struct packed {
      logic signed [RESULT_BITS-1:0] result_value;
      logic                          frame_end;
   } rsp_type;

   typedef pixel_type [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0] tap_array_type;
   typedef pixel_type [KERNEL_SIZE-1:0]                  column_type;
   typedef logic [KERNEL_SIZE-1:0][KERNEL_ROW_BITS-1:0]  kernel_type;

   typedef struct packed {
      logic                   emit;
      logic                   frame_end;
      logic                   case_a;
      logic [KERNEL_SIZE-1:0] row_ok;
      logic                   col0_ok;
   } tag_type;

endpackage

// ===== rtl/c2d_line_buf.sv =====
// ----------------------------------------------------------------------------
// c2d_line_buf
// Two line stores holding the rows one and two above the current row, with
// registered read and forwarding of the write in flight to the same column.
// ----------------------------------------------------------------------------
module c2d_line_buf #(
   parameter int MAX_WIDTH = c2d_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
   input  logic                         wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
   input  c2d_pkg::pixel_type           wr_pixel,
   output c2d_pkg::pixel_type           upper_q,
   output c2d_pkg::pixel_type           lower_q
);
   import c2d_pkg::*;

   pixel_type upper_mem [0:MAX_WIDTH-1];
   pixel_type lower_mem [0:MAX_WIDTH-1];

   pixel_type upper_rd_ff;
   pixel_type lower_rd_ff;
   logic      bypass_ff;
   pixel_type bypass_upper_ff;
   pixel_type bypass_lower_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         upper_mem[wr_addr] <= lower_q;
         lower_mem[wr_addr] <= wr_pixel;
      end
      if (rd_en) begin
         upper_rd_ff <= upper_mem[rd_addr];
         lower_rd_ff <= lower_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_ff <= 1'b0;
      end else if (rd_en) begin
         bypass_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         bypass_upper_ff <= lower_q;
         bypass_lower_ff <= wr_pixel;
      end
   end

   assign upper_q = bypass_ff ? bypass_upper_ff : upper_rd_ff;
   assign lower_q = bypass_ff ? bypass_lower_ff : lower_rd_ff;

endmodule

// ===== rtl/c2d_window.sv =====
// ----------------------------------------------------------------------------
// c2d_window
// 3x3 pixel window: shifts in one column per beat and registers the
// border-masked taps for the multiply stage.
// ----------------------------------------------------------------------------
module c2d_window (
   input  logic                   clock,
   input  logic                   advance,
   input  c2d_pkg::tag_type       tag,
   input  c2d_pkg::pixel_type     upper,
   input  c2d_pkg::pixel_type     lower,
   input  c2d_pkg::pixel_type     pixel,
   output c2d_pkg::tap_array_type taps
);
   import c2d_pkg::*;

   column_type    new_col;
   column_type    col1_ff;
   column_type    col2_ff;
   tap_array_type taps_ff;
   tap_array_type taps_in;

   assign new_col[0] = upper;
   assign new_col[1] = lower;
   assign new_col[2] = pixel;

   always_comb begin
      for (int a = 0; a < KERNEL_SIZE; a++) begin
         taps_in[a][0] = (tag.row_ok[a] && tag.col0_ok) ? col1_ff[a] : '0;
         taps_in[a][1] = tag.row_ok[a] ? col2_ff[a] : '0;
         taps_in[a][2] = (tag.row_ok[a] && !tag.case_a) ? new_col[a] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         col1_ff <= col2_ff;
         col2_ff <= new_col;
         taps_ff <= taps_in;
      end
   end

   assign taps = taps_ff;

endmodule

// ===== rtl/c2d_mac.sv =====
// ----------------------------------------------------------------------------
// c2d_mac
// Nine registered tap-by-coefficient products (kernel flipped) and their sum.
// ----------------------------------------------------------------------------
module c2d_mac (
   input  logic                                      clock,
   input  logic                                      load,
   input  c2d_pkg::tap_array_type                    taps,
   input  c2d_pkg::kernel_type                       kernel,
   output logic signed [c2d_pkg::RESULT_BITS-1:0]    sum
);
   import c2d_pkg::*;

   localparam int TAP_COUNT = KERNEL_SIZE * KERNEL_SIZE;

   logic signed [PRODUCT_BITS-1:0] prod_in [TAP_COUNT];
   logic signed [PRODUCT_BITS-1:0] prod_ff [TAP_COUNT];

   always_comb begin
      for (int a = 0; a < KERNEL_SIZE; a++) begin
         for (int b = 0; b < KERNEL_SIZE; b++) begin
            prod_in[a*KERNEL_SIZE+b] = $signed({1'b0, taps[a][b]})
               * $signed(kernel[KERNEL_SIZE-1-a][(KERNEL_SIZE-1-b)*COEF_BITS +: COEF_BITS]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   always_comb begin
      logic signed [RESULT_BITS-1:0] acc;
      acc = '0;
      for (int i = 0; i < TAP_COUNT; i++) begin
         acc = acc + RESULT_BITS'(prod_ff[i]);
      end
      sum = acc;
   end

endmodule

// ===== rtl/conv2d_3x3_zero_pad.sv =====
// ----------------------------------------------------------------------------
// conv2d_3x3_zero_pad
// Streaming same-size 3x3 convolution with zero padding, raster order.
//
//   channel  direction  beat
//   req_*    in         one pixel or drain step
//   rsp_*    out        one result value, frame_end on the last of a frame
//   csr_*    in         register write, index and data, always ready
//
// One beat a cycle sustained while rsp_ready stays high. Stages: position
// and line store read, window and tap mask, nine products, sum into the
// output register.
// Reset restores the register defaults and starts a new frame.
// A stalled rsp_ready backs up through the stages into req_ready.
// ----------------------------------------------------------------------------
module conv2d_3x3_zero_pad #(
   parameter int MAX_WIDTH  = c2d_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = c2d_pkg::DEFAULT_MAX_HEIGHT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  c2d_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output c2d_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [c2d_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [c2d_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import c2d_pkg::*;

   localparam int COL_BITS = $clog2(MAX_WIDTH);
   localparam int W_BITS   = $clog2(MAX_WIDTH + 1);
   localparam int ROW_BITS = $clog2(MAX_HEIGHT + 2);

   logic [DIM_BITS-1:0] width_ff;
   logic [DIM_BITS-1:0] height_ff;
   kernel_type          kernel_ff;

   logic [W_BITS-1:0]   w;
   logic [ROW_BITS-1:0] h;
   logic [ROW_BITS-1:0] h_last;

   logic [ROW_BITS-1:0] row_ff;
   logic [COL_BITS-1:0] col_ff;
   logic [ROW_BITS-1:0] row_in;
   logic [COL_BITS-1:0] col_in;
   logic [ROW_BITS-1:0] ir;
   logic [COL_BITS-1:0] ic;
   logic [W_BITS-1:0]   ic_inc;
   logic                restart;
   logic                case_b;
   tag_type             tag_in;
   pixel_type           pixel_in;

   logic                s1_valid_ff;
   logic [COL_BITS-1:0] s1_col_ff;
   pixel_type           s1_pixel_ff;
   tag_type             s1_tag_ff;
   logic                s2_valid_ff;
   logic                s2_frame_end_ff;
   logic                s3_valid_ff;
   logic                s3_frame_end_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;

   logic                out_rdy;
   logic                s3_rdy;
   logic                s2_rdy;
   logic                s1_rdy;
   logic                s1_adv;
   logic                req_acc;

   pixel_type                      upper_q;
   pixel_type                      lower_q;
   tap_array_type                  taps;
   logic signed [RESULT_BITS-1:0]  sum;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= RESET_IMAGE_WIDTH;
         height_ff    <= RESET_IMAGE_HEIGHT;
         kernel_ff[0] <= RESET_KERNEL_ROW0;
         kernel_ff[1] <= RESET_KERNEL_ROW1;
         kernel_ff[2] <= RESET_KERNEL_ROW2;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff     <= csr_data[DIM_BITS-1:0];
            CSR_IMAGE_HEIGHT: height_ff    <= csr_data[DIM_BITS-1:0];
            CSR_KERNEL_ROW0:  kernel_ff[0] <= csr_data;
            CSR_KERNEL_ROW1:  kernel_ff[1] <= csr_data;
            CSR_KERNEL_ROW2:  kernel_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         w = W_BITS'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         w = W_BITS'(MAX_WIDTH);
      end else begin
         w = W_BITS'(width_ff);
      end
      if (height_ff == '0) begin
         h = ROW_BITS'(1);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         h = ROW_BITS'(MAX_HEIGHT);
      end else begin
         h = ROW_BITS'(height_ff);
      end
   end

   assign h_last = h + ROW_BITS'(1);

   assign out_rdy   = !rsp_valid_ff || rsp_ready;
   assign s3_rdy    = !s3_valid_ff || out_rdy;
   assign s2_rdy    = !s2_valid_ff || s3_rdy;
   assign s1_rdy    = !s1_valid_ff || s2_rdy;
   assign s1_adv    = s1_valid_ff && s2_rdy;
   assign req_ready = s1_rdy;
   assign req_acc   = req_valid && s1_rdy;

   always_comb begin
      restart = (W_BITS'(col_ff) >= w) || (row_ff > h_last);
      ir      = restart ? '0 : row_ff;
      ic      = restart ? '0 : col_ff;
      ic_inc  = W_BITS'(ic) + W_BITS'(1);

      pixel_in = (!req_data.kind && (ir < h)) ? req_data.pixel : '0;

      tag_in.case_a    = (ic == '0) && (ir >= ROW_BITS'(2));
      case_b           = (ic != '0) && (ir >= ROW_BITS'(1)) && (ir <= h);
      tag_in.emit      = tag_in.case_a || case_b;
      tag_in.frame_end = (ir == h_last);
      tag_in.row_ok[0] = tag_in.case_a ? (ir >= ROW_BITS'(3)) : (ir >= ROW_BITS'(2));
      tag_in.row_ok[1] = 1'b1;
      tag_in.row_ok[2] = tag_in.case_a ? (ir <= h) : (ir < h);
      tag_in.col0_ok   = tag_in.case_a ? (w >= W_BITS'(2)) : (ic >= COL_BITS'(2));

      if (ir == h_last) begin
         row_in = '0;
         col_in = '0;
      end else if (ic_inc >= w) begin
         row_in = ir + ROW_BITS'(1);
         col_in = '0;
      end else begin
         row_in = ir;
         col_in = COL_BITS'(ic_inc);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (req_acc) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_rdy) begin
            s1_valid_ff <= req_acc;
         end
         if (s2_rdy) begin
            s2_valid_ff <= s1_valid_ff && s1_tag_ff.emit;
         end
         if (s3_rdy) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (out_rdy) begin
            rsp_valid_ff <= s3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_col_ff   <= ic;
         s1_pixel_ff <= pixel_in;
         s1_tag_ff   <= tag_in;
      end
      if (s1_adv) begin
         s2_frame_end_ff <= s1_tag_ff.frame_end;
      end
      if (s3_rdy && s2_valid_ff) begin
         s3_frame_end_ff <= s2_frame_end_ff;
      end
      if (out_rdy && s3_valid_ff) begin
         rsp_data_ff.result_value <= sum;
         rsp_data_ff.frame_end    <= s3_frame_end_ff;
      end
   end

   c2d_line_buf #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_buf (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_acc),
      .rd_addr  (ic),
      .wr_en    (s1_adv),
      .wr_addr  (s1_col_ff),
      .wr_pixel (s1_pixel_ff),
      .upper_q  (upper_q),
      .lower_q  (lower_q)
   );

   c2d_window u_window (
      .clock   (clock),
      .advance (s1_adv),
      .tag     (s1_tag_ff),
      .upper   (upper_q),
      .lower   (lower_q),
      .pixel   (s1_pixel_ff),
      .taps    (taps)
   );

   c2d_mac u_mac (
      .clock  (clock),
      .load   (s3_rdy && s2_valid_ff),
      .taps   (taps),
      .kernel (kernel_ff),
      .sum    (sum)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming 3x3 zero-padded convolution. A
// driver feeds pixel and drain beats from a queue; a line-store and window
// predictor works out each expected sum as a beat is taken, and a monitor
// checks every result beat against the oldest prediction. Covers directed
// border, drain and geometry cases, the largest and degenerate image sizes,
// then random frames under random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
   import c2d_pkg::*;

   localparam logic KIND_PIXEL       = 1'b0;
   localparam logic KIND_DRAIN       = 1'b1;
   localparam int   RANDOM_ITEMS     = 650;
   localparam int   SETTLE_CYCLES    = 12;
   localparam int   LONG_HOLD_CYCLES = 300;
   localparam int   HOLD_PHASE       = 1;
   localparam int   PAUSE_PHASE      = 2;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_type                   req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data  = '0;

   // predictor state
   logic [DIM_BITS-1:0]        geom_width;
   logic [DIM_BITS-1:0]        geom_height;
   logic [KERNEL_ROW_BITS-1:0] coef_rows [KERNEL_SIZE];
   pixel_type                  older_line [DEFAULT_MAX_WIDTH];
   pixel_type                  newer_line [DEFAULT_MAX_WIDTH];
   pixel_type                  tap_window [KERNEL_SIZE][KERNEL_SIZE];
   int unsigned                next_row;
   int unsigned                next_col;

   req_type beats_to_send [$];
   rsp_type pending_sums [$];
   int      queued_count     = 0;
   int      send_idle_pct    = 0;
   int      recv_idle_pct    = 0;
   int      send_gap_left    = 0;
   int      recv_stall_left  = 0;
   int      phase_id         = 0;
   int      held_phase       = -1;
   logic    long_hold_wanted = 1'b0;
   int      mismatches       = 0;

   conv2d_3x3_zero_pad dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic logic chance(input int pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   function automatic pixel_type random_pixel();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return pixel_type'($urandom());
      endcase
   endfunction

   function automatic logic [KERNEL_ROW_BITS-1:0] random_kernel_row();
      case ($urandom_range(0, 5))
         0: return 24'h7F7F7F;
         1: return 24'h808080;
         2: return '1;
         3: return '0;
         default: return KERNEL_ROW_BITS'($urandom());
      endcase
   endfunction

   function automatic int unsigned clamp_dim(input logic [DIM_BITS-1:0] d,
                                             input int unsigned limit);
      if (d == '0)
         return 1;
      return (d > limit) ? limit : d;
   endfunction

   function automatic logic signed [RESULT_BITS-1:0] weighted_sum(input tap_array_type taps);
      int                          acc;
      logic signed [COEF_BITS-1:0] c;
      acc = 0;
      for (int a = 0; a < KERNEL_SIZE; a++) begin
         for (int b = 0; b < KERNEL_SIZE; b++) begin
            c = coef_rows[KERNEL_SIZE-1-a][(KERNEL_SIZE-1-b)*COEF_BITS +: COEF_BITS];
            acc += int'(taps[a][b]) * int'(c);
         end
      end
      return acc[RESULT_BITS-1:0];
   endfunction

   task automatic compute_conv_result(input req_type beat);
      int unsigned   w;
      int unsigned   h;
      int unsigned   ir;
      int unsigned   ic;
      pixel_type     v;
      tap_array_type taps;
      logic          emit;
      logic          row_ok;
      rsp_type       sum;
      w = clamp_dim(geom_width, DEFAULT_MAX_WIDTH);
      h = clamp_dim(geom_height, DEFAULT_MAX_HEIGHT);
      emit = 1'b0;
      sum = '0;
      if (next_col >= w || next_row > h + 1) begin
         next_col = 0;
         next_row = 0;
      end
      ir = next_row;
      ic = next_col;
      v = (beat.kind == KIND_PIXEL && ir < h) ? beat.pixel : '0;
      // last column of the row two above, from the window before the shift
      if (ic == 0 && ir >= 2) begin
         for (int a = 0; a < KERNEL_SIZE; a++) begin
            row_ok = (a == 0) ? (ir >= 3) : (a == 2) ? (ir - 1 < h) : 1'b1;
            taps[a][0] = (row_ok && w >= 2) ? tap_window[a][1] : '0;
            taps[a][1] = row_ok ? tap_window[a][2] : '0;
            taps[a][2] = '0;
         end
         sum.result_value = weighted_sum(taps);
         emit = 1'b1;
      end
      for (int a = 0; a < KERNEL_SIZE; a++) begin
         tap_window[a][0] = tap_window[a][1];
         tap_window[a][1] = tap_window[a][2];
      end
      tap_window[0][2] = older_line[ic];
      tap_window[1][2] = newer_line[ic];
      tap_window[2][2] = v;
      if (ic >= 1 && ir >= 1 && ir <= h) begin
         for (int a = 0; a < KERNEL_SIZE; a++) begin
            row_ok = (a == 0) ? (ir >= 2) : (a == 2) ? (ir < h) : 1'b1;
            for (int b = 0; b < KERNEL_SIZE; b++)
               taps[a][b] = (row_ok && (b != 0 || ic >= 2)) ? tap_window[a][b] : '0;
         end
         sum.result_value = weighted_sum(taps);
         emit = 1'b1;
      end
      older_line[ic] = newer_line[ic];
      newer_line[ic] = v;
      if (emit) begin
         sum.frame_end = (ir == h + 1);
         pending_sums.push_back(sum);
      end
      if (ir == h + 1) begin
         next_row = 0;
         next_col = 0;
      end else begin
         next_col++;
         if (next_col >= w) begin
            next_col = 0;
            next_row++;
         end
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            compute_conv_result(req_data);
         if (req_valid && !req_ready) begin
            // hold the beat
         end else if (send_gap_left > 0) begin
            send_gap_left--;
            req_valid <= 1'b0;
         end else if (beats_to_send.size() != 0) begin
            req_data  <= beats_to_send.pop_front();
            req_valid <= 1'b1;
            if (send_idle_pct != 0 && chance(send_idle_pct))
               send_gap_left = $urandom_range(1, 13);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_sums.size() == 0) begin
               $error("result_value: expected none, actual %0d",
                      $signed(rsp_data.result_value));
               mismatches++;
            end else begin
               want = pending_sums.pop_front();
               if (rsp_data.result_value !== want.result_value) begin
                  $error("result_value: expected %0d, actual %0d",
                         $signed(want.result_value), $signed(rsp_data.result_value));
                  mismatches++;
               end
               if (rsp_data.frame_end !== want.frame_end) begin
                  $error("frame_end: expected %0b, actual %0b",
                         want.frame_end, rsp_data.frame_end);
                  mismatches++;
               end
            end
         end
         if (long_hold_wanted && held_phase != phase_id && rsp_valid) begin
            held_phase = phase_id;
            recv_stall_left = LONG_HOLD_CYCLES;
         end
         if (recv_stall_left > 0) begin
            recv_stall_left--;
            rsp_ready <= 1'b0;
         end else if (recv_idle_pct != 0 && chance(recv_idle_pct)) begin
            recv_stall_left = $urandom_range(1, 13) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_IMAGE_WIDTH:  geom_width   = value[DIM_BITS-1:0];
         CSR_IMAGE_HEIGHT: geom_height  = value[DIM_BITS-1:0];
         CSR_KERNEL_ROW0:  coef_rows[0] = value;
         CSR_KERNEL_ROW1:  coef_rows[1] = value;
         CSR_KERNEL_ROW2:  coef_rows[2] = value;
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic queue_beat(input logic kind, input pixel_type pixel);
      req_type b;
      b.kind  = kind;
      b.pixel = pixel;
      beats_to_send.push_back(b);
      queued_count++;
   endtask

   task automatic queue_frame(input int flip_pct);
      int unsigned w;
      int unsigned h;
      w = clamp_dim(geom_width, DEFAULT_MAX_WIDTH);
      h = clamp_dim(geom_height, DEFAULT_MAX_HEIGHT);
      for (int unsigned i = 0; i < w * h; i++)
         queue_beat(chance(flip_pct) ? KIND_DRAIN : KIND_PIXEL, random_pixel());
      for (int unsigned i = 0; i <= w; i++)
         queue_beat(chance(flip_pct) ? KIND_PIXEL : KIND_DRAIN, random_pixel());
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      @(negedge clock);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (beats_to_send.size() != 0 || req_valid || pending_sums.size() != 0);
   endtask

   task automatic wait_idle();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int  base;
      int  frames;
      int  n;
      int  pcts [3];
      logic calm;
      logic [DIM_BITS-1:0] new_w;
      logic [DIM_BITS-1:0] new_h;

      pcts = '{0, 10, 35};
      geom_width   = RESET_IMAGE_WIDTH;
      geom_height  = RESET_IMAGE_HEIGHT;
      coef_rows[0] = RESET_KERNEL_ROW0;
      coef_rows[1] = RESET_KERNEL_ROW1;
      coef_rows[2] = RESET_KERNEL_ROW2;
      for (int i = 0; i < DEFAULT_MAX_WIDTH; i++) begin
         older_line[i] = '0;
         newer_line[i] = '0;
      end
      for (int a = 0; a < KERNEL_SIZE; a++)
         for (int b = 0; b < KERNEL_SIZE; b++)
            tap_window[a][b] = '0;
      next_row = 0;
      next_col = 0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // full-scale negative sum, pixel beat inside the drain
      write_csr(CSR_IMAGE_WIDTH, CSR_DATA_BITS'(3));
      write_csr(CSR_IMAGE_HEIGHT, CSR_DATA_BITS'(3));
      write_csr(CSR_KERNEL_ROW0, 24'h808080);
      write_csr(CSR_KERNEL_ROW1, 24'h808080);
      write_csr(CSR_KERNEL_ROW2, 24'h808080);
      set_idling(0, 0);
      for (int i = 0; i < 9; i++)
         queue_beat(KIND_PIXEL, '1);
      queue_beat(KIND_DRAIN, '0);
      queue_beat(KIND_PIXEL, '1);
      queue_beat(KIND_DRAIN, '1);
      queue_beat(KIND_DRAIN, '0);
      wait_idle();

      // zero geometry acts as one by one
      write_csr(CSR_IMAGE_WIDTH, CSR_DATA_BITS'(0));
      write_csr(CSR_IMAGE_HEIGHT, CSR_DATA_BITS'(0));
      write_csr(CSR_KERNEL_ROW1, 24'h7F7F7F);
      @(negedge clock);
      queue_beat(KIND_PIXEL, '1);
      queue_beat(KIND_PIXEL, '1);
      queue_beat(KIND_DRAIN, '0);
      wait_idle();

      // drain beat inside the image, then geometry change mid frame
      write_csr(CSR_IMAGE_WIDTH, CSR_DATA_BITS'(4));
      write_csr(CSR_IMAGE_HEIGHT, CSR_DATA_BITS'(3));
      write_csr(CSR_KERNEL_ROW0, RESET_KERNEL_ROW0);
      write_csr(CSR_KERNEL_ROW1, 24'hFF01FF);
      write_csr(CSR_KERNEL_ROW2, RESET_KERNEL_ROW2);
      @(negedge clock);
      queue_beat(KIND_PIXEL, 8'h5A);
      queue_beat(KIND_DRAIN, '1);
      queue_beat(KIND_PIXEL, 8'hA5);
      queue_beat(KIND_PIXEL, '1);
      queue_beat(KIND_PIXEL, '0);
      queue_beat(KIND_PIXEL, 8'h3C);
      wait_idle();
      write_csr(CSR_IMAGE_WIDTH, CSR_DATA_BITS'(2));
      write_csr(CSR_IMAGE_HEIGHT, CSR_DATA_BITS'(2));
      set_idling(10, 10);
      queue_frame(0);
      wait_idle();

      // widest image, saturated; fills every line store entry
      write_csr(CSR_IMAGE_WIDTH, '1);
      write_csr(CSR_IMAGE_HEIGHT, CSR_DATA_BITS'(1));
      write_csr(CSR_KERNEL_ROW0, random_kernel_row());
      set_idling(5, 5);
      queue_frame(5);
      wait_idle();

      // tallest image, saturated
      write_csr(CSR_IMAGE_WIDTH, CSR_DATA_BITS'(1));
      write_csr(CSR_IMAGE_HEIGHT, '1);
      write_csr(CSR_KERNEL_ROW2, random_kernel_row());
      set_idling(5, 5);
      queue_frame(5);
      wait_idle();

      base = queued_count;
      while (queued_count - base < RANDOM_ITEMS) begin
         calm  = (queued_count - base) > RANDOM_ITEMS * 3 / 4;
         new_w = chance(8) ? '0 : DIM_BITS'($urandom_range(1, 12));
         new_h = chance(8) ? '0 : DIM_BITS'($urandom_range(1, 8));
         if (phase_id + 1 == HOLD_PHASE) begin
            new_w = DIM_BITS'(6);
            new_h = DIM_BITS'(4);
         end
         if (chance(80) || phase_id + 1 == HOLD_PHASE)
            write_csr(CSR_IMAGE_WIDTH, CSR_DATA_BITS'(new_w));
         if (chance(80) || phase_id + 1 == HOLD_PHASE)
            write_csr(CSR_IMAGE_HEIGHT, CSR_DATA_BITS'(new_h));
         for (int k = 0; k < KERNEL_SIZE; k++)
            if (chance(50))
               write_csr(CSR_INDEX_BITS'(CSR_KERNEL_ROW0 + k), random_kernel_row());
         if (calm)
            set_idling(0, 0);
         else
            set_idling(pcts[$urandom_range(0, 2)], pcts[$urandom_range(0, 2)]);
         phase_id++;
         long_hold_wanted = (phase_id == HOLD_PHASE);
         if (phase_id == HOLD_PHASE)
            send_idle_pct = 0;
         if (phase_id > PAUSE_PHASE && chance(15)) begin
            // broken sequence: leave the block mid frame
            n = $urandom_range(1, 20);
            for (int i = 0; i < n; i++)
               queue_beat(chance(50) ? KIND_DRAIN : KIND_PIXEL, random_pixel());
         end else begin
            frames = (phase_id == HOLD_PHASE) ? 3 :
                     (phase_id == PAUSE_PHASE) ? 2 : $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
               queue_frame(5);
               if (phase_id == PAUSE_PHASE && f == 0) begin
                  wait_drained();
                  repeat ($urandom_range(1, 13)) @(negedge clock);
               end
            end
         end
         wait_idle();
         long_hold_wanted = 1'b0;
      end

      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
